### rtl/core/crsf_pkg.sv
package crsf_pkg;

  localparam int NUM_CHANNELS_DEF = 16;
  localparam int CHAN_W           = 11;
  localparam int PAYLOAD_BYTES    = 22;
  localparam int CMD_Q_DEPTH      = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;

  localparam logic [7:0] FRAME_LEN = 8'd24;
  localparam logic [7:0] CRC_POLY  = 8'hD5;

  localparam logic [7:0]  SYNC_RST   = 8'd200;
  localparam logic [7:0]  TYPE_RST   = 8'd22;
  localparam logic [10:0] OFFSET_RST = 11'd172;
  localparam logic [15:0] GAIN_RST   = 16'd3999;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_TYPE = 2'd1,
    STAT_LEN  = 2'd2,
    STAT_CRC  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_SYNC       = 3'd0,
    CFG_TYPE       = 3'd1,
    CFG_STICK_OFF  = 3'd2,
    CFG_STICK_GAIN = 3'd3,
    CFG_AUX_OFF    = 3'd4,
    CFG_AUX_GAIN   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FR_HUNT,
    FR_LEN,
    FR_TYPE,
    FR_PAYLOAD,
    FR_CRC
  } fr_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_MUL,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] frame_type;
  } fr_cfg_t;

  typedef struct packed {
    logic [10:0] stick_offset;
    logic [15:0] stick_gain;
    logic [10:0] aux_offset;
    logic [15:0] aux_gain;
  } bk_cfg_t;

endpackage

### rtl/core/crsf_in_if.sv
interface crsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       after_idle;

  modport source (output valid, output rx_byte, output after_idle, input ready);
  modport sink (input valid, input rx_byte, input after_idle, output ready);
endinterface

### rtl/core/crsf_out_if.sv
interface crsf_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel_index;
  logic [10:0]        raw_value;
  logic signed [15:0] scaled_percent;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output channel_index, output raw_value,
                  output scaled_percent, output status, output last, input ready);
  modport sink (input valid, input channel_index, input raw_value,
                input scaled_percent, input status, input last, output ready);
endinterface

### rtl/core/crsf_cfg_if.sv
interface crsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/crsf_ram.sv
module crsf_ram #(
  parameter int WIDTH  = 11,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/crsf_cmd_fifo.sv
module crsf_cmd_fifo import crsf_pkg::*; #(
  parameter int DEPTH = CMD_Q_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t wr,
  input  logic  pop,
  output logic  full,
  output q_rd_t rd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t          entry [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == (PW+1)'(DEPTH));
  assign rd.valid = (count != '0);
  assign rd.cmd   = entry[rptr];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/crsf_front.sv
module crsf_front import crsf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  crsf_in_if.sink           rx,
  input  fr_cfg_t           cfg,
  input  logic              q_full,
  input  logic              frame_done,
  output q_wr_t             q_wr,
  output logic              st_we,
  output logic [ADDR_W-1:0] st_addr,
  output logic [CHAN_W-1:0] st_wdata
);

  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  fr_state_t   state, state_next, cur;
  logic [7:0]  crc, crc_next, crc_upd;
  logic [17:0] acc, acc_next, acc_sum;
  logic [4:0]  held, held_next, held_sum;
  logic [4:0]  filled, filled_next;
  logic [4:0]  cnt, cnt_next;
  logic        frame_out, frame_out_next;
  logic        accept;

  assign rx.ready = !q_full && !frame_out;
  assign accept   = rx.valid && rx.ready;
  assign cur      = rx.after_idle ? FR_HUNT : state;
  assign crc_upd  = crc8_byte((cur == FR_TYPE) ? 8'h00 : crc, rx.rx_byte);
  assign acc_sum  = acc | (18'(rx.rx_byte) << held);
  assign held_sum = held + 5'd8;

  always_comb begin
    state_next = state;
    if (accept) begin
      case (cur)
        FR_HUNT:    state_next = (rx.rx_byte == cfg.sync_value) ? FR_LEN : FR_HUNT;
        FR_LEN:     state_next = (rx.rx_byte == FRAME_LEN) ? FR_TYPE : FR_HUNT;
        FR_TYPE:    state_next = (rx.rx_byte == cfg.frame_type) ? FR_PAYLOAD : FR_HUNT;
        FR_PAYLOAD: state_next = (cnt == 5'(PAYLOAD_BYTES - 1)) ? FR_CRC : FR_PAYLOAD;
        FR_CRC:     state_next = FR_HUNT;
        default:    state_next = FR_HUNT;
      endcase
    end
  end

  always_comb begin
    crc_next       = crc;
    acc_next       = acc;
    held_next      = held;
    filled_next    = filled;
    cnt_next       = cnt;
    frame_out_next = frame_out;
    q_wr.push      = 1'b0;
    q_wr.cmd       = '{status: STAT_OK};
    st_we          = 1'b0;
    st_addr        = filled[ADDR_W-1:0];
    st_wdata       = acc_sum[CHAN_W-1:0];
    if (frame_done) begin
      frame_out_next = 1'b0;
    end
    if (accept) begin
      case (cur)
        FR_HUNT: begin
          crc_next    = '0;
          acc_next    = '0;
          held_next   = '0;
          filled_next = '0;
          cnt_next    = '0;
        end
        FR_LEN: begin
          if (rx.rx_byte != FRAME_LEN) begin
            q_wr.push = 1'b1;
            q_wr.cmd  = '{status: STAT_LEN};
          end
        end
        FR_TYPE: begin
          if (rx.rx_byte != cfg.frame_type) begin
            q_wr.push = 1'b1;
            q_wr.cmd  = '{status: STAT_TYPE};
          end else begin
            crc_next = crc_upd;
          end
        end
        FR_PAYLOAD: begin
          crc_next = crc_upd;
          cnt_next = cnt + 1'b1;
          if (held_sum >= 5'(CHAN_W)) begin
            st_we       = (filled < 5'(NUM_CHANNELS));
            acc_next    = acc_sum >> CHAN_W;
            held_next   = held_sum - 5'(CHAN_W);
            filled_next = filled + 1'b1;
          end else begin
            acc_next  = acc_sum;
            held_next = held_sum;
          end
        end
        FR_CRC: begin
          q_wr.push   = 1'b1;
          crc_next    = '0;
          acc_next    = '0;
          held_next   = '0;
          filled_next = '0;
          cnt_next    = '0;
          if (rx.rx_byte == crc) begin
            q_wr.cmd       = '{status: STAT_OK};
            frame_out_next = 1'b1;
          end else begin
            q_wr.cmd = '{status: STAT_CRC};
          end
        end
        default: begin
          crc_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FR_HUNT;
      crc       <= '0;
      acc       <= '0;
      held      <= '0;
      filled    <= '0;
      cnt       <= '0;
      frame_out <= 1'b0;
    end else begin
      state     <= state_next;
      crc       <= crc_next;
      acc       <= acc_next;
      held      <= held_next;
      filled    <= filled_next;
      cnt       <= cnt_next;
      frame_out <= frame_out_next;
    end
  end

endmodule

### rtl/core/crsf_back.sv
module crsf_back import crsf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  q_rd_t             q,
  input  bk_cfg_t           cfg,
  input  logic [CHAN_W-1:0] st_rdata,
  output logic              pop,
  output logic [ADDR_W-1:0] st_raddr,
  output logic              frame_done,
  crsf_out_if.source        res
);

  localparam logic [3:0] LAST_IDX = 4'(NUM_CHANNELS - 1);

  bk_state_t          state, state_next;
  logic [3:0]         idx;
  logic [CHAN_W-1:0]  raw_q;
  logic signed [28:0] prod;
  logic signed [11:0] diff;
  logic signed [16:0] gain_s;
  logic signed [20:0] quot;
  logic [15:0]        pct_sat;
  logic               is_stick;
  logic               free;
  logic               load_status;
  logic               load_chan;

  logic               out_valid;
  logic [3:0]         out_index;
  logic [CHAN_W-1:0]  out_raw;
  logic [15:0]        out_pct;
  status_t            out_status;
  logic               out_last;

  assign res.valid          = out_valid;
  assign res.channel_index  = out_index;
  assign res.raw_value      = out_raw;
  assign res.scaled_percent = out_pct;
  assign res.status         = out_status;
  assign res.last           = out_last;

  assign free     = !out_valid || res.ready;
  assign st_raddr = idx[ADDR_W-1:0];
  assign is_stick = (idx < 4'd4);
  assign diff     = $signed({1'b0, st_rdata})
                  - $signed({1'b0, is_stick ? cfg.stick_offset : cfg.aux_offset});
  assign gain_s   = $signed({1'b0, is_stick ? cfg.stick_gain : cfg.aux_gain});
  assign quot     = prod[28:8];

  always_comb begin
    if (quot > 21'sd32767) begin
      pct_sat = 16'h7FFF;
    end else if (quot < -21'sd32768) begin
      pct_sat = 16'h8000;
    end else begin
      pct_sat = quot[15:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q.valid && q.cmd.status == STAT_OK) begin
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_MUL;
      BK_MUL:  state_next = BK_EMIT;
      BK_EMIT: begin
        if (free) begin
          state_next = (idx == LAST_IDX) ? BK_IDLE : BK_READ;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    load_status = 1'b0;
    load_chan   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q.valid) begin
          if (q.cmd.status == STAT_OK) begin
            pop = 1'b1;
          end else if (free) begin
            pop         = 1'b1;
            load_status = 1'b1;
          end
        end
      end
      BK_EMIT: load_chan = free;
      default: load_chan = 1'b0;
    endcase
  end

  assign frame_done = load_chan && (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (state == BK_MUL) begin
      raw_q <= st_rdata;
      prod  <= diff * gain_s;
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      out_index  <= '0;
      out_raw    <= '0;
      out_pct    <= '0;
      out_status <= q.cmd.status;
      out_last   <= 1'b1;
    end else if (load_chan) begin
      out_index  <= idx;
      out_raw    <= raw_q;
      out_pct    <= pct_sat;
      out_status <= STAT_OK;
      out_last   <= (idx == LAST_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_IDLE) begin
        idx <= '0;
      end else if (load_chan) begin
        idx <= idx + 1'b1;
      end
      if (load_status || load_chan) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/crsf_rc_channel_frame_parser.sv
// Channel  Dir  Transfer payload
// rx       in   rx_byte, after_idle
// res      out  channel_index, raw_value, scaled_percent, status, last
// cfg      in   index, data (always ready)
//
// A good frame gives NUM_CHANNELS results, each through the steps store read,
// multiply and output load, the last of which waits on res; rx holds ready low
// from the CRC byte until the last channel result is loaded.
// Reset clears the parser, the command queue and the output register.
module crsf_rc_channel_frame_parser import crsf_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input logic        clk,
  input logic        rst,
  crsf_in_if.sink    rx,
  crsf_out_if.source res,
  crsf_cfg_if.sink   cfg
);

  localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  fr_cfg_t           fr_cfg;
  bk_cfg_t           bk_cfg;
  q_wr_t             q_wr;
  q_rd_t             q_rd;
  logic              q_full;
  logic              q_pop;
  logic              frame_done;
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [ADDR_W-1:0] st_raddr;
  logic [CHAN_W-1:0] st_wdata;
  logic [CHAN_W-1:0] st_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_cfg.sync_value   <= SYNC_RST;
      fr_cfg.frame_type   <= TYPE_RST;
      bk_cfg.stick_offset <= OFFSET_RST;
      bk_cfg.stick_gain   <= GAIN_RST;
      bk_cfg.aux_offset   <= OFFSET_RST;
      bk_cfg.aux_gain     <= GAIN_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_t'(cfg.index))
        CFG_SYNC:       fr_cfg.sync_value   <= cfg.data[7:0];
        CFG_TYPE:       fr_cfg.frame_type   <= cfg.data[7:0];
        CFG_STICK_OFF:  bk_cfg.stick_offset <= cfg.data[10:0];
        CFG_STICK_GAIN: bk_cfg.stick_gain   <= cfg.data;
        CFG_AUX_OFF:    bk_cfg.aux_offset   <= cfg.data[10:0];
        CFG_AUX_GAIN:   bk_cfg.aux_gain     <= cfg.data;
        default:        fr_cfg.sync_value   <= fr_cfg.sync_value;
      endcase
    end
  end

  crsf_front #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (fr_cfg),
    .q_full    (q_full),
    .frame_done(frame_done),
    .q_wr      (q_wr),
    .st_we     (st_we),
    .st_addr   (st_waddr),
    .st_wdata  (st_wdata)
  );

  crsf_cmd_fifo #(
    .DEPTH(CMD_Q_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (q_wr),
    .pop (q_pop),
    .full(q_full),
    .rd  (q_rd)
  );

  crsf_ram #(
    .WIDTH (CHAN_W),
    .DEPTH (NUM_CHANNELS),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  crsf_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q         (q_rd),
    .cfg       (bk_cfg),
    .st_rdata  (st_rdata),
    .pop       (q_pop),
    .st_raddr  (st_raddr),
    .frame_done(frame_done),
    .res       (res)
  );

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != STAT_OK) |-> res.last)
    else $error("status result without last");

  a_status_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != STAT_OK) |->
      (res.raw_value == '0 && res.scaled_percent == '0 && res.channel_index == '0))
    else $error("status result carries channel data");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> (res.valid && res.last && res.channel_index == 4'(NUM_CHANNELS - 1)))
    else $error("frame burst did not end on the last channel");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !q_full)
    else $error("command queue overflow");

endmodule

### tb/crsf_tb_pkg.sv
package crsf_tb_pkg;

  import crsf_pkg::*;

  // CRC-8, polynomial 0xD5, MSB first
  function automatic logic [7:0] crc8_d5(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### tb/crsf_frame_checker.sv
module crsf_frame_checker import crsf_pkg::*, crsf_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  crsf_in_if          rx,
  crsf_out_if         res,
  crsf_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned backlog,
  output int unsigned channel_reports,
  output int unsigned status_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POS_HUNT = 0;
  localparam int unsigned POS_LEN  = 1;
  localparam int unsigned POS_TYPE = 2;
  localparam int unsigned POS_CRC  = 3 + PAYLOAD_BYTES;

  typedef struct {
    logic [3:0]         chan;
    logic [10:0]        raw;
    logic signed [15:0] pct;
    status_t            stat;
    logic               is_last;
  } frame_report_t;

  frame_report_t frame_reports[$];

  logic [7:0]  sync_val;
  logic [7:0]  type_code;
  logic [10:0] stick_off;
  logic [15:0] stick_gain;
  logic [10:0] aux_off;
  logic [15:0] aux_gain;

  int unsigned fpos;
  int unsigned held;
  int unsigned filled;
  int unsigned bit_acc;
  logic [7:0]  crc;
  logic [10:0] chan_store[NUM_CHANNELS_DEF];

  // floor(((raw - offset) * gain) / 256), saturated to 16 bits signed
  function automatic logic signed [15:0] scale_pct(logic [10:0] raw, logic [10:0] off,
                                                   logic [15:0] gain);
    longint r;
    longint o;
    longint g;
    longint p;
    r = raw;
    o = off;
    g = gain;
    p = ((r - o) * g) >>> 8;
    if (p > 32767) p = 32767;
    else if (p < -32768) p = -32768;
    return 16'(p);
  endfunction

  task automatic restart_hunt();
    fpos    = POS_HUNT;
    crc     = 8'h00;
    bit_acc = 0;
    held    = 0;
    filled  = 0;
  endtask

  task automatic push_status(status_t s);
    frame_report_t r;
    r.chan    = '0;
    r.raw     = '0;
    r.pct     = '0;
    r.stat    = s;
    r.is_last = 1'b1;
    frame_reports.push_back(r);
  endtask

  task automatic parse_rx_byte(logic [7:0] b, logic idle);
    frame_report_t r;
    int k;
    if (idle) restart_hunt();
    if (fpos == POS_HUNT) begin
      if (b == sync_val) begin
        restart_hunt();
        fpos = POS_LEN;
      end
    end else if (fpos == POS_LEN) begin
      if (b != FRAME_LEN) begin
        restart_hunt();
        push_status(STAT_LEN);
      end else begin
        fpos = POS_TYPE;
      end
    end else if (fpos == POS_TYPE) begin
      if (b != type_code) begin
        restart_hunt();
        push_status(STAT_TYPE);
      end else begin
        crc  = crc8_d5(8'h00, b);
        fpos = POS_TYPE + 1;
      end
    end else if (fpos < POS_CRC) begin
      crc     = crc8_d5(crc, b);
      bit_acc = (bit_acc | (32'(b) << held)) & 32'h3FFFF;
      held    = held + 8;
      while (held >= CHAN_W) begin
        if (filled < NUM_CHANNELS_DEF) chan_store[filled] = 11'(bit_acc);
        filled  = filled + 1;
        bit_acc = bit_acc >> CHAN_W;
        held    = held - CHAN_W;
      end
      fpos = fpos + 1;
    end else begin
      if (b != crc) begin
        restart_hunt();
        push_status(STAT_CRC);
      end else begin
        for (k = 0; k < NUM_CHANNELS_DEF; k++) begin
          r.chan    = 4'(k);
          r.raw     = chan_store[k];
          r.pct     = (k < 4) ? scale_pct(chan_store[k], stick_off, stick_gain)
                              : scale_pct(chan_store[k], aux_off, aux_gain);
          r.stat    = STAT_OK;
          r.is_last = (k == NUM_CHANNELS_DEF - 1);
          frame_reports.push_back(r);
        end
        restart_hunt();
      end
    end
  endtask

  task automatic flag_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_report();
    frame_report_t r;
    if (frame_reports.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual channel_index %0d status %0d",
               $time, res.channel_index, res.status);
      return;
    end
    r = frame_reports.pop_front();
    if (r.stat == STAT_OK) channel_reports++;
    else status_reports++;
    flag_field("channel_index", r.chan, res.channel_index);
    flag_field("raw_value", r.raw, res.raw_value);
    flag_field("scaled_percent", r.pct, res.scaled_percent);
    flag_field("status", r.stat, res.status);
    flag_field("last", r.is_last, res.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sync_val   = SYNC_RST;
      type_code  = TYPE_RST;
      stick_off  = OFFSET_RST;
      stick_gain = GAIN_RST;
      aux_off    = OFFSET_RST;
      aux_gain   = GAIN_RST;
      restart_hunt();
      foreach (chan_store[k]) chan_store[k] = '0;
      frame_reports.delete();
      mismatches      = 0;
      channel_reports = 0;
      status_reports  = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg_idx_t'(cfg.index))
          CFG_SYNC:       sync_val   = cfg.data[7:0];
          CFG_TYPE:       type_code  = cfg.data[7:0];
          CFG_STICK_OFF:  stick_off  = cfg.data[10:0];
          CFG_STICK_GAIN: stick_gain = cfg.data;
          CFG_AUX_OFF:    aux_off    = cfg.data[10:0];
          CFG_AUX_GAIN:   aux_gain   = cfg.data;
          default: ;
        endcase
      end
      if (rx.valid === 1'b1 && rx.ready === 1'b1) parse_rx_byte(rx.rx_byte, rx.after_idle);
      if (res.valid === 1'b1 && res.ready === 1'b1) check_report();
    end
    backlog = frame_reports.size();
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crsf_pkg::*;
  import crsf_tb_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_GAP        = 16;
  localparam int unsigned PHASE_BYTES    = 24;

  typedef enum {FLAW_NONE, FLAW_CRC, FLAW_LEN, FLAW_TYPE, FLAW_CUT} frame_flaw_t;

  logic clk;
  logic rst;

  crsf_in_if  rx_if();
  crsf_out_if res_if();
  crsf_cfg_if cfg_if();

  int unsigned mismatches;
  int unsigned backlog;
  int unsigned channel_reports;
  int unsigned status_reports;

  logic [7:0]  cur_sync;
  logic [7:0]  cur_type;
  logic [10:0] frame_chans[NUM_CHANNELS_DEF];
  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  bit          hold_req;

  crsf_rc_channel_frame_parser i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  crsf_frame_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .rx              (rx_if),
    .res             (res_if),
    .cfg             (cfg_if),
    .mismatches      (mismatches),
    .backlog         (backlog),
    .channel_reports (channel_reports),
    .status_reports  (status_reports)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("crsf_rc_channel_frame_parser regression: fail");
      $finish;
    end
  end

  // result side: random stall stretches, plus one long hold-off on request
  initial begin
    int unsigned stretch;
    int unsigned mode;
    int unsigned hold_left;
    stretch   = 0;
    mode      = 0;
    hold_left = 0;
    forever begin
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(4, 64);
          mode    = $urandom_range(0, 3);
        end
        stretch--;
        case (mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ($urandom_range(0, 3) != 0);
          2:       res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= 1'($urandom_range(0, 1));
        endcase
      end
      @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b, logic idle);
    if (burst_left == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    rx_if.valid      <= 1'b1;
    rx_if.rx_byte    <= b;
    rx_if.after_idle <= idle;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_drained();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] d_sync, logic [15:0] d_type,
                              logic [15:0] d_soff, logic [15:0] d_sgain,
                              logic [15:0] d_aoff, logic [15:0] d_again);
    cfg_idx_t    order[6];
    logic [15:0] vals[6];
    int          k;
    order = '{CFG_SYNC, CFG_TYPE, CFG_STICK_OFF, CFG_STICK_GAIN, CFG_AUX_OFF, CFG_AUX_GAIN};
    vals  = '{d_sync, d_type, d_soff, d_sgain, d_aoff, d_again};
    for (k = 0; k < 6; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[k];
      cfg_if.data  <= vals[k];
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
    end
    cfg_if.valid <= 1'b0;
    cur_sync = d_sync[7:0];
    cur_type = d_type[7:0];
    settings_used++;
  endtask

  task automatic fill_random_chans();
    foreach (frame_chans[k]) begin
      case ($urandom_range(0, 3))
        0:       frame_chans[k] = 11'h000;
        1:       frame_chans[k] = 11'h7FF;
        default: frame_chans[k] = 11'($urandom_range(0, 2047));
      endcase
    end
  endtask

  // sync, length, type, packed payload, crc; the flaw breaks it at one point
  task automatic send_frame(frame_flaw_t flaw);
    logic [175:0] payload;
    logic [7:0]   crc;
    logic [7:0]   b;
    int           cut;
    int           k;
    foreach (frame_chans[j]) payload[j*11 +: 11] = frame_chans[j];
    send_byte(cur_sync, ($urandom_range(0, 3) != 0));
    if (flaw == FLAW_LEN) begin
      do b = 8'($urandom_range(0, 255)); while (b == FRAME_LEN);
      send_byte(b, 1'b0);
      return;
    end
    send_byte(FRAME_LEN, 1'b0);
    if (flaw == FLAW_TYPE) begin
      do b = 8'($urandom_range(0, 255)); while (b == cur_type);
      send_byte(b, 1'b0);
      return;
    end
    send_byte(cur_type, 1'b0);
    crc = crc8_d5(8'h00, cur_type);
    cut = (flaw == FLAW_CUT) ? $urandom_range(0, PAYLOAD_BYTES) : PAYLOAD_BYTES + 1;
    for (k = 0; k < PAYLOAD_BYTES; k++) begin
      if (k == cut) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
      b   = payload[k*8 +: 8];
      crc = crc8_d5(crc, b);
      send_byte(b, 1'b0);
    end
    if (cut == PAYLOAD_BYTES) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    if (flaw == FLAW_CRC) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(crc, 1'b0);
  endtask

  // mostly clean frames with random content, the rest broken frames and noise
  task automatic run_random(int unsigned n);
    int unsigned stop;
    int unsigned pick;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 15) == 0) wait_drained();
      fill_random_chans();
      pick = $urandom_range(0, 99);
      if (pick < 55) send_frame(FLAW_NONE);
      else if (pick < 65) send_frame(FLAW_CRC);
      else if (pick < 73) send_frame(FLAW_LEN);
      else if (pick < 81) send_frame(FLAW_TYPE);
      else if (pick < 90) send_frame(FLAW_CUT);
      else begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    rst              <= 1'b1;
    rx_if.valid      <= 1'b0;
    rx_if.rx_byte    <= 8'h00;
    rx_if.after_idle <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_SYNC;
    cfg_if.data      <= 16'h0000;
    cur_sync         = SYNC_RST;
    cur_type         = TYPE_RST;
    bytes_sent       = 0;
    burst_left       = 0;
    settings_used    = 1;
    hold_req         = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(SYNC_RST, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(SYNC_RST, 1'b0);
    send_byte(FRAME_LEN, 1'b0);
    send_byte(8'hFF, 1'b0);
    foreach (frame_chans[k]) frame_chans[k] = k[0] ? 11'h7FF : 11'h000;
    frame_chans[0] = OFFSET_RST;
    frame_chans[4] = OFFSET_RST;
    send_frame(FLAW_NONE);
    fill_random_chans();
    send_frame(FLAW_CRC);
    send_frame(FLAW_CUT);
    wait_drained();

    // random registers; long result hold-off while clean frames keep coming
    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    hold_req = 1'b1;
    repeat (3) begin
      fill_random_chans();
      send_frame(FLAW_NONE);
    end
    run_random(PHASE_BYTES);
    wait_drained();

    // saturation both ways, unused data bits set
    program_regs(16'hFF00, 16'h00FF, 16'hF800, 16'hFFFF, 16'h07FF, 16'hFFFF);
    run_random(PHASE_BYTES);
    wait_drained();

    program_regs(16'h00FF, 16'hFF00, 16'h07FF, 16'h0000, 16'hF800, 16'h8000);
    run_random(PHASE_BYTES);
    wait_drained();

    $display("%0d rx bytes under %0d register settings gave %0d channel and %0d status results",
             bytes_sent, settings_used, channel_reports, status_reports);
    if (mismatches == 0 && backlog == 0) begin
      $display("crsf_rc_channel_frame_parser regression: pass");
    end else begin
      $display("crsf_rc_channel_frame_parser regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/crsf_pkg.sv
rtl/core/crsf_in_if.sv
rtl/core/crsf_out_if.sv
rtl/core/crsf_cfg_if.sv
rtl/core/crsf_ram.sv
rtl/core/crsf_cmd_fifo.sv
rtl/core/crsf_front.sv
rtl/core/crsf_back.sv
rtl/core/crsf_rc_channel_frame_parser.sv
tb/crsf_tb_pkg.sv
tb/crsf_frame_checker.sv
tb/tb.sv
